// ===== sv/sld_pkg.sv =====
// Shared types, constants and register codes for the sync/length/checksum deframer.
package sld_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;

	localparam int REG_AW  = 3;
	localparam int DATA_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 6;

	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_TYPE  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUM   = 3'd5
	} phase_t;

	typedef enum logic {
		EM_IDLE = 1'b0,
		EM_RUN  = 1'b1
	} emit_state_t;

	// Request from the parser to the emitter when a frame passes its checksum.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] ftype;
		logic [BYTE_W-1:0] len;
	} start_req_t;

	// Emitter status seen by the parser.
	typedef struct packed {
		logic busy;
		logic slot_free;
	} emit_status_t;

endpackage

// ===== sv/sld_store.sv =====
// Payload store: one write port and one read port with a registered read.
module sld_store #(
	parameter int DEPTH = sld_pkg::MAX_PAYLOAD_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [sld_pkg::BYTE_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [sld_pkg::BYTE_W-1:0] rd_data
);
	import sld_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read register holds its value until the next read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/sld_parser.sv =====
// Input parser: sync hunt, header capture, payload write and checksum test.
module sld_parser #(
	parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF,
	parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
	parameter int LW          = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sld_pkg::BYTE_W-1:0] rx_byte,
	input  logic [sld_pkg::BYTE_W-1:0] sync_first,
	input  logic [sld_pkg::BYTE_W-1:0] sync_second,
	input  sld_pkg::emit_status_t      status,
	output sld_pkg::start_req_t        start,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [sld_pkg::BYTE_W-1:0] wr_data
);
	import sld_pkg::*;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] type_q;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     count_q;
	logic [BYTE_W-1:0] sum_q;
	logic              accept;
	logic              len_too_big;
	logic [LW-1:0]     count_inc;
	logic [BYTE_W-1:0] sum_next;

	// The checksum byte may produce an empty-frame result, so it waits for a free slot.
	assign in_ready    = !status.busy && ((phase_q != PH_SUM) || status.slot_free);
	assign accept      = in_valid && in_ready;
	assign len_too_big = ({1'b0, rx_byte} > 9'(MAX_PAYLOAD));
	assign count_inc   = LW'(count_q + LW'(1));
	assign sum_next    = sum_q + rx_byte;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_SYNC2: begin
				if (rx_byte == sync_second) begin
					phase_d = PH_TYPE;
				end else if (rx_byte == sync_first) begin
					phase_d = PH_SYNC2;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_TYPE: phase_d = PH_LEN;
			PH_LEN: begin
				if (len_too_big) begin
					phase_d = PH_SYNC1;
				end else if (rx_byte == 8'd0) begin
					phase_d = PH_SUM;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (count_inc == len_q) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: phase_d = PH_SYNC1;
			default: phase_d = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
		endcase
	end

	always_comb begin
		wr_en       = accept && (phase_q == PH_DATA);
		wr_addr     = count_q[AW-1:0];
		wr_data     = rx_byte;
		start.valid = accept && (phase_q == PH_SUM) && (rx_byte == sum_q);
		start.ftype = type_q;
		start.len   = BYTE_W'(len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			type_q  <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_TYPE: begin
					type_q <= rx_byte;
					sum_q  <= rx_byte;
				end
				PH_LEN: begin
					sum_q   <= sum_next;
					count_q <= '0;
					if (!len_too_big) begin
						len_q <= LW'(rx_byte);
					end
				end
				PH_DATA: begin
					sum_q   <= sum_next;
					count_q <= count_inc;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/sld_emit.sv =====
// Frame emitter: reads the payload store in order and drives the result register.
module sld_emit #(
	parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF,
	parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
	parameter int LW          = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sld_pkg::start_req_t         start,
	output sld_pkg::emit_status_t       status,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [sld_pkg::BYTE_W-1:0]  rd_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sld_pkg::BYTE_W-1:0]  frame_type,
	output logic [sld_pkg::BYTE_W-1:0]  data_byte,
	output logic [sld_pkg::INDEX_W-1:0] byte_index,
	output logic                        last_of_frame,
	output logic                        empty_frame
);
	import sld_pkg::*;

	emit_state_t        state_q, state_d;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      rd_cnt_q;
	logic [BYTE_W-1:0]  type_q;
	logic               pend_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic               last_s1;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  type_out_q;
	logic [BYTE_W-1:0]  data_out_q;
	logic [INDEX_W-1:0] idx_out_q;
	logic               last_out_q;
	logic               empty_out_q;
	logic               slot_free;
	logic               load_out;
	logic               load_empty;
	logic               issue;
	logic               issue_last;
	logic [LW-1:0]      rd_cnt_inc;

	assign slot_free  = !out_valid_q || out_ready;
	assign load_out   = pend_s1 && slot_free;
	assign load_empty = start.valid && (start.len == '0);
	assign rd_cnt_inc = LW'(rd_cnt_q + LW'(1));
	assign issue_last = (rd_cnt_inc == len_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			EM_IDLE: begin
				if (start.valid && (start.len != '0)) begin
					state_d = EM_RUN;
				end
			end
			EM_RUN: begin
				if (issue && issue_last) begin
					state_d = EM_IDLE;
				end
			end
			default: state_d = EM_IDLE;
		endcase
	end

	// While a frame runs, a read goes out whenever the read register is free or hands its byte on this cycle.
	always_comb begin
		issue       = (state_q == EM_RUN) && (!pend_s1 || load_out);
		rd_en       = issue;
		rd_addr     = rd_cnt_q[AW-1:0];
		status.busy = (state_q == EM_RUN) || pend_s1;
		status.slot_free = slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pend_s1     <= issue || (pend_s1 && !load_out);
			out_valid_q <= load_out || load_empty || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (start.valid) begin
			type_q   <= start.ftype;
			len_q    <= LW'(start.len);
			rd_cnt_q <= '0;
		end else if (issue) begin
			rd_cnt_q <= rd_cnt_inc;
		end
		if (issue) begin
			idx_s1  <= INDEX_W'(rd_cnt_q);
			last_s1 <= issue_last;
		end
		if (load_out) begin
			type_out_q  <= type_q;
			data_out_q  <= rd_data;
			idx_out_q   <= idx_s1;
			last_out_q  <= last_s1;
			empty_out_q <= 1'b0;
		end else if (load_empty) begin
			type_out_q  <= start.ftype;
			data_out_q  <= '0;
			idx_out_q   <= '0;
			last_out_q  <= 1'b1;
			empty_out_q <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_type    = type_out_q;
	assign data_byte     = data_out_q;
	assign byte_index    = idx_out_q;
	assign last_of_frame = last_out_q;
	assign empty_frame   = empty_out_q;

endmodule

// ===== sv/sync_length_checksum_deframer_core.sv =====
// Top level of the sync/length/checksum deframer with its APB register port.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+--------------------------------------------
//  input    | in        | in_valid / in_ready     | rx_byte
//  result   | out       | out_valid / out_ready   | frame_type, data_byte, byte_index,
//           |           |                         | last_of_frame, empty_frame
//  config   | in        | APB psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// Header, payload and checksum bytes are taken at one item per cycle while in_ready is high.
// A good frame of N payload bytes is streamed out at one result per cycle while
// out_ready is high, after a start through the emitter state and the registered read
// of the payload store; input is held off (in_ready low) until the last read has been
// handed to the result register. Reset clears the parser, the emitter and both sync registers; the payload store
// needs no clearing pass, because only entries written in the current frame are read.
// A stalled result register holds its item and stops further store reads once the read register is full.
module sync_length_checksum_deframer_core #(
	parameter int MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sld_pkg::BYTE_W-1:0]  rx_byte,
	// Result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sld_pkg::BYTE_W-1:0]  frame_type,
	output logic [sld_pkg::BYTE_W-1:0]  data_byte,
	output logic [sld_pkg::INDEX_W-1:0] byte_index,
	output logic                        last_of_frame,
	output logic                        empty_frame,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sld_pkg::REG_AW-1:0]  paddr,
	input  logic [sld_pkg::DATA_W-1:0]  pwdata,
	output logic [sld_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import sld_pkg::*;

	// Store address width and the width of a length or count up to MAX_PAYLOAD.
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LW = $clog2(MAX_PAYLOAD + 1);

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic              cfg_write;
	logic              reg_sel;

	start_req_t        start;
	emit_status_t      status;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;

	// Registers sit at byte addresses 0 and 4; address bit 2 picks the register,
	// so the low address bits alias onto the register of the same word.
	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= '0;
			sync_second_q <= '0;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_SYNC_FIRST:  sync_first_q  <= pwdata[BYTE_W-1:0];
				REG_SYNC_SECOND: sync_second_q <= pwdata[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SYNC_FIRST:  prdata = DATA_W'(sync_first_q);
			REG_SYNC_SECOND: prdata = DATA_W'(sync_second_q);
			default:         prdata = '0;
		endcase
	end

	// The parser walks the frame byte by byte and fills the store with payload.
	sld_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW),
		.LW          (LW)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.status      (status),
		.start       (start),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	// Writes happen only while a frame is coming in and reads only while one is
	// going out, so the two ports never touch the same entry in the same cycle.
	sld_store #(
		.DEPTH   (MAX_PAYLOAD),
		.AW      (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The emitter drains a checked frame from the store into the result register.
	sld_emit #(
		.MAX_PAYLOAD   (MAX_PAYLOAD),
		.AW            (AW),
		.LW            (LW)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.status        (status),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_type    (frame_type),
		.data_byte     (data_byte),
		.byte_index    (byte_index),
		.last_of_frame (last_of_frame),
		.empty_frame   (empty_frame)
	);

endmodule

// ===== sv/sld_checker.sv =====
// Port-level checker for the deframer and the bind that attaches it.
module sld_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sld_pkg::BYTE_W-1:0]  frame_type,
	input logic [sld_pkg::BYTE_W-1:0]  data_byte,
	input logic [sld_pkg::INDEX_W-1:0] byte_index,
	input logic                        last_of_frame,
	input logic                        empty_frame
);
	import sld_pkg::*;

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_type) &&
		$stable(data_byte) && $stable(byte_index) && $stable(last_of_frame) &&
		$stable(empty_frame))
		else $error("result changed while stalled");

	// An empty-frame result is a single zero result that closes the frame.
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_frame |-> last_of_frame && (data_byte == '0) &&
		(byte_index == '0))
		else $error("malformed empty-frame result");

	// Results of one frame follow back to back with rising index.
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_frame |=> out_valid &&
		(byte_index == INDEX_W'($past(byte_index) + 1'b1)) &&
		(frame_type == $past(frame_type)) && !empty_frame)
		else $error("gap or index skip inside a frame");

	// No input is taken while a frame is still being streamed.
	a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_frame |-> !in_ready)
		else $error("input accepted in the middle of a frame");

endmodule

bind sync_length_checksum_deframer_core sld_checker u_sld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.frame_type    (frame_type),
	.data_byte     (data_byte),
	.byte_index    (byte_index),
	.last_of_frame (last_of_frame),
	.empty_frame   (empty_frame)
);
